[hw/rtl/abm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abm_pkg: shared constants, types and helpers
// Command codes, field widths and small byte helpers for the bitmap core.
// ----------------------------------------------------------------------------
package abm_pkg;

	localparam int MAX_SLOTS_DEF = 1024;
	localparam int SLOTS_RESET   = 1024;

	localparam int CMD_W     = 3;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int FIRST_W   = 10;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLR     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FLIP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLR_ALL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET_ALL = 3'd5;

	typedef struct packed {
		logic bit_value;
		logic range_error;
		logic all_set;
		logic all_clear;
		logic found_set;
	} abm_flags_t;

	// number of ones in a byte
	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] s;
		s = 4'd0;
		for (int i = 0; i < 8; i++) begin
			s = s + 4'(v[i]);
		end
		return s;
	endfunction

	// position of the lowest set bit, 0 when none
	function automatic logic [2:0] low8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// n low bits set, n in 0..8
	function automatic logic [7:0] lowmask8(input logic [3:0] n);
		logic [8:0] m;
		m = (9'd1 << n) - 9'd1;
		return m[7:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/allocation_bitmap_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// allocation_bitmap_core: slot bitmap with lowest-set search and set count
// Single-bit commands: a byte read-modify-write, then group flags -> group
// word -> byte search; the next item is taken only once the result has moved
// into the output register.
// Bulk commands: one byte written per cycle over the padded range.
// A slot count write holds off items until the recount sweep is done.
// Reset: asynchronous; a clearing pass over the whole store follows.
// ----------------------------------------------------------------------------
//
// Storage
//   bitmap RAM  : one byte per eight slots, ceil(MAX_SLOTS/8) entries.
//   summary RAM : one word per group of eight bytes, a bit per byte that is
//                 nonzero.
//   group flags : one flip-flop per summary word that is nonzero.
//
// The lowest set slot is searched over the whole store: if any slot below
// the slot count is set, the lowest set bit of the store lies below it too,
// so no masking is needed in the search. The used-slot and padded counts are
// kept as running totals and rebuilt by a sweep when the slot count changes.
//
// No items are taken during the clearing pass or a recount; configuration
// writes are taken at any time. The output register lets the next item in
// while a result still waits on m_tready.
module allocation_bitmap_core #(
	parameter int MAX_SLOTS = abm_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [abm_pkg::CNT_W-1:0]     cfg_wdata,  // slot_count
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [2:0] cmd, [12:3] bit_index, [15:13] zero
	input  wire logic [abm_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [0] bit_value, [1] range_error, [2] all_set, [3] all_clear,
	// [13:4] first_set, [14] found_set, [25:15] set_count, [31:26] zero
	output logic      [abm_pkg::M_TDATA_W-1:0] m_tdata
);

	import abm_pkg::*;

	localparam int STORE_BYTES = (MAX_SLOTS + 7) / 8;
	localparam int NG          = (STORE_BYTES + 7) / 8;
	localparam int GW          = (NG > 1) ? $clog2(NG) : 1;
	localparam int ABW         = GW + 3;
	localparam int PAD_W       = M_TDATA_W - (5 + FIRST_W + CNT_W);

	// memory ports
	logic           bm_we, bm_re, sm_we, sm_re;
	logic [ABW-1:0] bm_waddr, bm_raddr;
	logic [GW-1:0]  sm_waddr, sm_raddr;
	logic [7:0]     bm_wdata, bm_rdata, sm_wdata, sm_rdata;

	// group flag port
	logic          gf_we, gf_val;
	logic [GW-1:0] gf_idx, gf_low;

	// result from the sequencer
	logic               res_valid, res_ready;
	abm_flags_t         res_flags;
	logic [FIRST_W-1:0] res_first;
	logic [CNT_W-1:0]   res_count;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	abm_ctrl #(
		.MAX_SLOTS(MAX_SLOTS),
		.GW       (GW),
		.ABW      (ABW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_valid  (s_tvalid),
		.s_cmd    (s_tdata[CMD_W-1:0]),
		.s_idx    (s_tdata[CMD_W+IDX_W-1:CMD_W]),
		.s_ready  (s_tready),
		.bm_we    (bm_we),
		.bm_waddr (bm_waddr),
		.bm_wdata (bm_wdata),
		.bm_re    (bm_re),
		.bm_raddr (bm_raddr),
		.bm_rdata (bm_rdata),
		.sm_we    (sm_we),
		.sm_waddr (sm_waddr),
		.sm_wdata (sm_wdata),
		.sm_re    (sm_re),
		.sm_raddr (sm_raddr),
		.sm_rdata (sm_rdata),
		.gf_we    (gf_we),
		.gf_idx   (gf_idx),
		.gf_val   (gf_val),
		.gf_low   (gf_low),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_flags(res_flags),
		.res_first(res_first),
		.res_count(res_count)
	);

	// bitmap bytes
	abm_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES),
		.ADDR_W(ABW)
	) u_bitmap_ram (
		.clk  (clk),
		.we   (bm_we),
		.waddr(bm_waddr),
		.wdata(bm_wdata),
		.re   (bm_re),
		.raddr(bm_raddr),
		.rdata(bm_rdata)
	);

	// per-byte nonzero summary, eight bytes per word
	abm_ram #(
		.WIDTH (8),
		.DEPTH (NG),
		.ADDR_W(GW)
	) u_summary_ram (
		.clk  (clk),
		.we   (sm_we),
		.waddr(sm_waddr),
		.wdata(sm_wdata),
		.re   (sm_re),
		.raddr(sm_raddr),
		.rdata(sm_rdata)
	);

	abm_seek #(
		.NG(NG),
		.GW(GW)
	) u_seek (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (gf_we),
		.widx  (gf_idx),
		.wval  (gf_val),
		.low   (gf_low)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {
				{PAD_W{1'b0}},
				res_count,
				res_flags.found_set,
				res_first,
				res_flags.all_clear,
				res_flags.all_set,
				res_flags.range_error,
				res_flags.bit_value
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// found and all-clear come from the same running count
	a_found_vs_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_flags.found_set != res_flags.all_clear))
		else $error("found_set and all_clear disagree");

	// a rejected index never reports a bit
	a_rerr_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_flags.range_error) |-> !res_flags.bit_value)
		else $error("bit_value set on range error");

	// at least one slot is used, so a full map has a set slot
	a_full_found: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_flags.all_set) |-> res_flags.found_set)
		else $error("all_set without found_set");

	// one item at a time: the sequencer leaves idle after taking an item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item taken while the previous one is in flight");

endmodule
`default_nettype wire

[hw/rtl/abm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module abm_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

[hw/rtl/abm_seek.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abm_seek: per-group nonzero flags and lowest-group encoder
// One flag per group of eight bytes; gives the lowest group holding a set bit.
// ----------------------------------------------------------------------------
module abm_seek #(
	parameter int NG = 16,
	parameter int GW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [GW-1:0] widx,
	input  wire logic          wval,
	output logic      [GW-1:0] low
);

	logic [NG-1:0] flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (we) begin
			flags_q[widx] <= wval;
		end
	end

	always_comb begin
		low = '0;
		for (int i = NG - 1; i >= 0; i--) begin
			if (flags_q[i]) begin
				low = GW'(i);
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/abm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abm_ctrl: command sequencer for the bitmap core
// Read-modify-write of one byte, bulk fill sweeps, recount after a slot
// count change, and the three-step lowest-set-bit search.
// ----------------------------------------------------------------------------
module abm_ctrl #(
	parameter int MAX_SLOTS = abm_pkg::MAX_SLOTS_DEF,
	parameter int GW        = 4,
	parameter int ABW       = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [abm_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire logic                        s_valid,
	input  wire logic [abm_pkg::CMD_W-1:0]   s_cmd,
	input  wire logic [abm_pkg::IDX_W-1:0]   s_idx,
	output logic                             s_ready,
	output logic                             bm_we,
	output logic      [ABW-1:0]              bm_waddr,
	output logic      [7:0]                  bm_wdata,
	output logic                             bm_re,
	output logic      [ABW-1:0]              bm_raddr,
	input  wire logic [7:0]                  bm_rdata,
	output logic                             sm_we,
	output logic      [GW-1:0]               sm_waddr,
	output logic      [7:0]                  sm_wdata,
	output logic                             sm_re,
	output logic      [GW-1:0]               sm_raddr,
	input  wire logic [7:0]                  sm_rdata,
	output logic                             gf_we,
	output logic      [GW-1:0]               gf_idx,
	output logic                             gf_val,
	input  wire logic [GW-1:0]               gf_low,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output abm_pkg::abm_flags_t              res_flags,
	output logic      [abm_pkg::FIRST_W-1:0] res_first,
	output logic      [abm_pkg::CNT_W-1:0]   res_count
);

	import abm_pkg::*;

	localparam int STORE_BYTES = (MAX_SLOTS + 7) / 8;
	localparam int BITW        = ABW + 3;
	localparam int SW          = $clog2(MAX_SLOTS + 1);
	localparam int OW          = $clog2(STORE_BYTES * 8 + 1);
	localparam int RST_SLOTS   = (SLOTS_RESET > MAX_SLOTS) ? MAX_SLOTS : SLOTS_RESET;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_BULK = 3'd2;
	localparam logic [2:0] ST_RCNT = 3'd3;
	localparam logic [2:0] ST_RDRN = 3'd4;
	localparam logic [2:0] ST_S1   = 3'd5;
	localparam logic [2:0] ST_S2   = 3'd6;
	localparam logic [2:0] ST_S3   = 3'd7;

	localparam logic [ABW-1:0] STORE_LAST = ABW'(STORE_BYTES - 1);

	logic [2:0]       state_q;
	logic [SW-1:0]    slots_q;
	logic             rcnt_pend_q;
	logic             clr_q;
	logic             fill_q;
	logic [ABW-1:0]   k_q;
	logic             v_s1;
	logic [ABW-1:0]   k_s1;
	logic [OW-1:0]    ones_q;
	logic [SW-1:0]    used_q;
	logic [CMD_W-1:0] cmd_q;
	logic [ABW-1:0]   baddr_q;
	logic [2:0]       bpos_q;
	logic             in_used_q;
	logic             rerr_q;
	logic             bitv_q;
	logic [GW-1:0]    g_s1;
	logic [ABW-1:0]   byte_s2;

	logic [31:0]    slots_w, nbytes_w, padded_w, full_w, idx_w, cfg_w, clamp_w, ks1_w;
	logic [31:0]    first_w;
	logic [ABW-1:0] last_byte, limit_last;
	logic           accept, bulk_in, in_rerr, grp_end, k_at_end;
	logic [7:0]     new_byte, mbit, sbit, sw_new, lm, blk_word, umask, byte_hit;
	logic           old_bit, new_bit;
	logic [3:0]     pop_all, pop_used;
	logic [BITW-1:0] first_bit;

	// geometry from the current slot count
	assign slots_w   = 32'(slots_q);
	assign nbytes_w  = (slots_w + 32'd7) >> 3;
	assign padded_w  = nbytes_w << 3;
	assign full_w    = slots_w >> 3;
	assign last_byte = ABW'(nbytes_w - 32'd1);
	assign limit_last = clr_q ? STORE_LAST : last_byte;

	// input decode
	assign s_ready = (state_q == ST_IDLE) && !rcnt_pend_q && !cfg_we;
	assign accept  = s_valid && s_ready;
	assign bulk_in = (s_cmd == CMD_CLR_ALL) || (s_cmd == CMD_SET_ALL);
	assign idx_w   = 32'(s_idx);
	assign in_rerr = !bulk_in && (idx_w >= padded_w);

	// slot count saturation
	assign cfg_w   = 32'(cfg_wdata);
	assign clamp_w = (cfg_w == 32'd0) ? 32'd1 :
		((cfg_w > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : cfg_w);

	// single-bit modify
	assign mbit    = 8'd1 << bpos_q;
	assign old_bit = bm_rdata[bpos_q];
	always_comb begin
		unique case (cmd_q)
			CMD_SET:  new_byte = bm_rdata | mbit;
			CMD_CLR:  new_byte = bm_rdata & ~mbit;
			CMD_FLIP: new_byte = bm_rdata ^ mbit;
			default:  new_byte = bm_rdata;
		endcase
	end
	assign new_bit = new_byte[bpos_q];
	assign sbit    = 8'd1 << baddr_q[2:0];
	assign sw_new  = (|new_byte) ? (sm_rdata | sbit) : (sm_rdata & ~sbit);

	// bulk fill: last group keeps flags of bytes past the range
	assign k_at_end = (k_q == limit_last);
	assign grp_end  = (k_q[2:0] == 3'd7) || k_at_end;
	assign lm       = lowmask8({1'b0, k_q[2:0]} + 4'd1);
	assign blk_word = clr_q ? 8'h00 :
		(k_at_end ? ((sm_rdata & ~lm) | (fill_q ? lm : 8'h00)) : {8{fill_q}});

	// recount: mask of the bits of a byte that lie below the slot count
	assign ks1_w = 32'(k_s1);
	assign umask = (ks1_w < full_w) ? 8'hFF :
		((ks1_w == full_w) ? lowmask8({1'b0, slots_q[2:0]}) : 8'h00);
	assign pop_all  = pop8(bm_rdata);
	assign pop_used = pop8(bm_rdata & umask);

	// memory ports
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = k_q;
		bm_wdata = {8{fill_q}};
		bm_re    = 1'b0;
		bm_raddr = k_q;
		sm_we    = 1'b0;
		sm_waddr = k_q[ABW-1:3];
		sm_wdata = blk_word;
		sm_re    = 1'b0;
		sm_raddr = gf_low;
		gf_we    = 1'b0;
		gf_idx   = k_q[ABW-1:3];
		gf_val   = |blk_word;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					bm_re    = 1'b1;
					bm_raddr = idx_w[ABW+2:3];
					sm_re    = 1'b1;
					sm_raddr = bulk_in ? last_byte[ABW-1:3] : idx_w[ABW+2:6];
				end
			end
			ST_MOD: begin
				if (!rerr_q) begin
					bm_we    = 1'b1;
					bm_waddr = baddr_q;
					bm_wdata = new_byte;
					sm_we    = 1'b1;
					sm_waddr = baddr_q[ABW-1:3];
					sm_wdata = sw_new;
					gf_we    = 1'b1;
					gf_idx   = baddr_q[ABW-1:3];
					gf_val   = |sw_new;
				end
			end
			ST_BULK: begin
				bm_we = 1'b1;
				sm_we = grp_end;
				gf_we = grp_end;
			end
			ST_RCNT: begin
				bm_re = 1'b1;
			end
			ST_S1: begin
				sm_re = 1'b1;
			end
			ST_S2: begin
				bm_re    = 1'b1;
				bm_raddr = {g_s1, low8(sm_rdata)};
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BULK;
			slots_q     <= SW'(RST_SLOTS);
			rcnt_pend_q <= 1'b0;
			clr_q       <= 1'b1;
			fill_q      <= 1'b0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			ones_q      <= '0;
			used_q      <= '0;
		end else begin
			v_s1 <= (state_q == ST_RCNT);
			if (cfg_we) begin
				slots_q     <= SW'(clamp_w);
				rcnt_pend_q <= 1'b1;
			end
			if (v_s1) begin
				ones_q <= ones_q + OW'(pop_all);
				used_q <= used_q + SW'(pop_used);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rcnt_pend_q && !cfg_we) begin
						rcnt_pend_q <= 1'b0;
						ones_q      <= '0;
						used_q      <= '0;
						k_q         <= '0;
						state_q     <= ST_RCNT;
					end else if (accept) begin
						k_q    <= '0;
						clr_q  <= 1'b0;
						fill_q <= (s_cmd == CMD_SET_ALL);
						if (bulk_in) begin
							state_q <= ST_BULK;
							if (s_cmd == CMD_SET_ALL) begin
								ones_q <= OW'(padded_w);
								used_q <= slots_q;
							end else begin
								ones_q <= '0;
								used_q <= '0;
							end
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (!rerr_q && (new_bit != old_bit)) begin
						ones_q <= new_bit ? (ones_q + OW'(1)) : (ones_q - OW'(1));
						if (in_used_q) begin
							used_q <= new_bit ? (used_q + SW'(1)) : (used_q - SW'(1));
						end
					end
					state_q <= ST_S1;
				end
				ST_BULK: begin
					if (k_at_end) begin
						clr_q   <= 1'b0;
						state_q <= clr_q ? ST_IDLE : ST_S1;
					end else begin
						k_q <= k_q + ABW'(1);
					end
				end
				ST_RCNT: begin
					if (k_q == last_byte) begin
						state_q <= ST_RDRN;
					end else begin
						k_q <= k_q + ABW'(1);
					end
				end
				ST_RDRN: state_q <= ST_IDLE;
				ST_S1:   state_q <= ST_S2;
				ST_S2:   state_q <= ST_S3;
				ST_S3: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-item payload
	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (accept) begin
			cmd_q     <= s_cmd;
			baddr_q   <= idx_w[ABW+2:3];
			bpos_q    <= s_idx[2:0];
			in_used_q <= idx_w < slots_w;
			rerr_q    <= in_rerr;
			bitv_q    <= 1'b0;
		end
		if ((state_q == ST_MOD) && !rerr_q) begin
			bitv_q <= old_bit;
		end
		if (state_q == ST_S1) begin
			g_s1 <= gf_low;
		end
		if (state_q == ST_S2) begin
			byte_s2 <= {g_s1, low8(sm_rdata)};
		end
	end

	// result
	assign byte_hit  = bm_rdata;
	assign first_bit = {byte_s2, low8(byte_hit)};
	assign first_w   = 32'(first_bit);

	assign res_valid             = (state_q == ST_S3);
	assign res_flags.bit_value   = bitv_q;
	assign res_flags.range_error = rerr_q;
	assign res_flags.all_set     = (used_q == slots_q);
	assign res_flags.all_clear   = (used_q == '0);
	assign res_flags.found_set   = (used_q != '0);
	assign res_first = (used_q != '0) ? first_w[FIRST_W-1:0] : '0;
	assign res_count = CNT_W'(ones_q);

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for allocation_bitmap_core
// Drives bitmap commands over the slave stream and compares every result
// with a bit-exact shadow of the store, across several slot counts.
// ----------------------------------------------------------------------------
module tb;
	import abm_pkg::*;

	// spare command codes, decoded by the core as a plain get
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	localparam int STORE_BYTES = (MAX_SLOTS_DEF + 7) / 8;
	// cycles with no handshake at all before the run is called dead; the
	// slowest legal gap is a bulk command or recount plus a stall
	localparam int STALL_LIMIT = 4000;
	// drain time at the end, about one bulk command at full size
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic               bit_value;
		logic               range_error;
		logic               all_set;
		logic               all_clear;
		logic [FIRST_W-1:0] first_set;
		logic               found_set;
		logic [CNT_W-1:0]   set_count;
	} bitmap_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CNT_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // [2:0] cmd, [12:3] bit_index, [15:13] zero
	logic                 m_tvalid;
	logic                 m_tready;
	// [0] bit_value, [1] range_error, [2] all_set, [3] all_clear,
	// [13:4] first_set, [14] found_set, [25:15] set_count, [31:26] zero
	logic [M_TDATA_W-1:0] m_tdata;

	// shadow of the store and of the slot count register
	logic [7:0]       shadow_bytes [STORE_BYTES];
	logic [CNT_W-1:0] shadow_slots;
	// statuses still owed by the core, oldest first
	bitmap_status_t   status_q [$];

	int err_count;
	int quiet_cycles;
	bit idle_on;      // random gaps on both sides when set

	always #1 clk = ~clk;

	allocation_bitmap_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	// slot count as the core uses it: zero acts as one, big values saturate
	function automatic int used_slots();
		int n;
		n = int'(shadow_slots);
		if (n < 1) n = 1;
		if (n > MAX_SLOTS_DEF) n = MAX_SLOTS_DEF;
		return n;
	endfunction

	// addressable bits: used slots padded up to a whole byte
	function automatic int padded_bits();
		return ((used_slots() + 7) / 8) * 8;
	endfunction

	// applies one command to the shadow store and returns the status it owes
	function automatic bitmap_status_t apply_command(input logic [CMD_W-1:0] op,
			input logic [IDX_W-1:0] idx);
		bitmap_status_t r;
		int used;
		int span;
		int hits;
		used = used_slots();
		span = padded_bits();
		r = '0;
		r.all_set = 1'b1;
		if (op == CMD_CLR_ALL || op == CMD_SET_ALL) begin
			// bulk ops touch the padded range only, padding bits included
			for (int b = 0; b < span / 8; b++) begin
				shadow_bytes[b] = (op == CMD_SET_ALL) ? 8'hFF : 8'h00;
			end
		end else if (int'(idx) >= span) begin
			r.range_error = 1'b1;
		end else begin
			r.bit_value = shadow_bytes[idx >> 3][idx[2:0]];
			case (op)
				CMD_SET:  shadow_bytes[idx >> 3][idx[2:0]] = 1'b1;
				CMD_CLR:  shadow_bytes[idx >> 3][idx[2:0]] = 1'b0;
				CMD_FLIP: shadow_bytes[idx >> 3][idx[2:0]] = ~shadow_bytes[idx >> 3][idx[2:0]];
				default:  ;
			endcase
		end
		// search and full/empty flags over used slots, count over padded range
		hits = 0;
		for (int i = 0; i < span; i++) begin
			if (shadow_bytes[i / 8][i % 8]) begin
				hits++;
				if (i < used && !r.found_set) begin
					r.found_set = 1'b1;
					r.first_set = FIRST_W'(i);
				end
			end else if (i < used) begin
				r.all_set = 1'b0;
			end
		end
		r.all_clear = ~r.found_set;
		r.set_count = CNT_W'(hits);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver side
	// ------------------------------------------------------------------

	// offers one item, optionally after a gap, and returns at its acceptance
	// edge; tvalid stays up so back-to-back items need no second assignment
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, idx, op};
		do @(posedge clk); while (!s_tready);
		status_q.push_back(apply_command(op, idx));
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// register writes only with the core idle: input stopped, nothing owed
	task automatic write_slot_count(input logic [CNT_W-1:0] value);
		end_burst();
		while (status_q.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		shadow_slots = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: ready most of the time, with random stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin : result_check
		bitmap_status_t want;
		bitmap_status_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.bit_value   = m_tdata[0];
			got.range_error = m_tdata[1];
			got.all_set     = m_tdata[2];
			got.all_clear   = m_tdata[3];
			got.first_set   = m_tdata[13:4];
			got.found_set   = m_tdata[14];
			got.set_count   = m_tdata[25:15];
			if (status_q.size() == 0) begin
				report_mismatch("unexpected result (raw word)", int'(m_tdata), 0);
			end else begin
				want = status_q.pop_front();
				if (got.bit_value != want.bit_value)
					report_mismatch("bit_value", got.bit_value, want.bit_value);
				if (got.range_error != want.range_error)
					report_mismatch("range_error", got.range_error, want.range_error);
				if (got.all_set != want.all_set)
					report_mismatch("all_set", got.all_set, want.all_set);
				if (got.all_clear != want.all_clear)
					report_mismatch("all_clear", got.all_clear, want.all_clear);
				if (got.first_set != want.first_set)
					report_mismatch("first_set", got.first_set, want.first_set);
				if (got.found_set != want.found_set)
					report_mismatch("found_set", got.found_set, want.found_set);
				if (got.set_count != want.set_count)
					report_mismatch("set_count", got.set_count, want.set_count);
			end
		end
	end

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// single-bit ops on the full 1024-slot map, both ends of the index
	task automatic test_single_bit_ops();
		send_item(CMD_GET,    10'd0);      // empty map: all clear, none found
		send_item(CMD_SET,    10'd0);
		send_item(CMD_SET,    10'd1023);
		send_item(CMD_GET,    10'd1023);
		send_item(CMD_FLIP,   10'h200);
		send_item(CMD_FLIP,   10'h1FF);
		send_item(CMD_FLIP,   10'h200);    // flip back
		send_item(CMD_CLR,    10'd0);      // lowest set moves up
		send_item(CMD_SPARE6, 10'd1023);   // spare codes read only
		send_item(CMD_SPARE7, 10'h2AA);
		send_item(CMD_GET,    10'h155);
	endtask

	// bulk ops ignore the index and report no bit
	task automatic test_bulk_ops();
		send_item(CMD_SET_ALL, 10'h3FF);   // every slot set
		send_item(CMD_GET,     10'd7);
		send_item(CMD_CLR,     10'd8);
		send_item(CMD_CLR_ALL, 10'd5);
	endtask

	// padding, out-of-range indexes and slot counts outside 1..1024
	task automatic test_range_limits();
		write_slot_count(11'd13);          // 13 used slots, 16 addressable
		send_item(CMD_SET,     10'd15);    // padding bit: counted, not searched
		send_item(CMD_GET,     10'd16);    // first index past the padding
		send_item(CMD_FLIP,    10'd1023);
		send_item(CMD_SET_ALL, 10'd0);     // sets padding too
		send_item(CMD_CLR,     10'd3);
		send_item(CMD_CLR_ALL, 10'd0);
		write_slot_count(11'd0);           // behaves as one slot
		send_item(CMD_SET,     10'd0);
		send_item(CMD_SET,     10'd8);
		write_slot_count(11'd2047);        // saturates at the store size
		send_item(CMD_GET,     10'd1023);
		send_item(CMD_SET,     10'd1023);
	endtask

	// bytes outside a shrunk range keep their contents
	task automatic test_retained_bytes();
		write_slot_count(11'd1024);
		send_item(CMD_SET, 10'd1000);
		write_slot_count(11'd8);
		send_item(CMD_GET, 10'd0);
		write_slot_count(11'd1024);
		send_item(CMD_GET, 10'd1000);
	endtask

	// random commands over a series of slot counts; the last phases run
	// without any gaps
	task automatic test_random_traffic();
		int slot_plan [13] = '{1024, 3, 1, 8, 9, 0, 64, 100, 2047, -1, -1, 1024, 17};
		int r;
		logic [CMD_W-1:0] op;
		logic [IDX_W-1:0] idx;
		for (int p = 0; p < 13; p++) begin
			idle_on = (p < 10);
			if (slot_plan[p] < 0)
				write_slot_count(CNT_W'($urandom_range(1, 1024)));
			else
				write_slot_count(CNT_W'(slot_plan[p]));
			for (int n = 0; n < 85; n++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					op = CMD_CLR_ALL;
				else if (r < 6)
					op = CMD_SET_ALL;
				else if (r < 10)
					op = r[0] ? CMD_SPARE6 : CMD_SPARE7;
				else
					op = CMD_W'($urandom_range(0, 3));
				// mostly inside the padded range, now and then anywhere
				if ($urandom_range(0, 9) == 0)
					idx = IDX_W'($urandom);
				else
					idx = IDX_W'($urandom_range(0, padded_bits() - 1));
				send_item(op, idx);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		err_count    = 0;
		quiet_cycles = 0;
		idle_on      = 1'b1;
		shadow_slots = CNT_W'(SLOTS_RESET);
		for (int b = 0; b < STORE_BYTES; b++) shadow_bytes[b] = 8'h00;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;    // core clears its store before taking items

		test_single_bit_ops();
		test_bulk_ops();
		test_range_limits();
		test_retained_bytes();
		test_random_traffic();

		end_burst();
		while (status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/abm_pkg.sv
hw/rtl/abm_ram.sv
hw/rtl/abm_seek.sv
hw/rtl/abm_ctrl.sv
hw/rtl/allocation_bitmap_core.sv
bench/tb.sv
